/* rtl/dsfc_pkg.sv */
// Shared types and codes for the DSP status-flag unit.
package dsfc_pkg;

  typedef enum logic [1:0] {
    OP_WIDE_UPDATE  = 2'd0,
    OP_SHORT_UPDATE = 2'd1,
    OP_SET_LZ       = 2'd2,
    OP_CHECK        = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    CC_GE     = 4'h0,
    CC_L      = 4'h1,
    CC_G      = 4'h2,
    CC_LE     = 4'h3,
    CC_NZ     = 4'h4,
    CC_Z      = 4'h5,
    CC_NC     = 4'h6,
    CC_C      = 4'h7,
    CC_NO32   = 4'h8,
    CC_O32    = 4'h9,
    CC_A      = 4'hA,
    CC_NA     = 4'hB,
    CC_LNZ    = 4'hC,
    CC_LZ     = 4'hD,
    CC_O      = 4'hE,
    CC_ALWAYS = 4'hF
  } cond_e;

  // Bit 0 is carry, bit 7 is sticky overflow.
  typedef struct packed {
    logic sticky;
    logic logic_zero;
    logic top2;
    logic over32;
    logic sign;
    logic zero;
    logic overflow;
    logic carry;
  } flags_t;

  // Registered copy of one transfer on the input side.
  typedef struct packed {
    op_e                operation;
    logic signed [63:0] wide_value;
    logic signed [15:0] short_value;
    logic               carry_in;
    logic               overflow_in;
    logic               over32_in;
    logic               logic_zero_in;
    cond_e              condition;
  } item_t;

endpackage

/* rtl/dsfc_flag_logic.sv */
// Flag update and condition-code evaluation for one item.
module dsfc_flag_logic (
  input  dsfc_pkg::item_t  item_i,
  input  dsfc_pkg::flags_t flags_i,
  output dsfc_pkg::flags_t flags_o,
  output logic             met_o
);

  logic less;
  logic cond_a;
  logic met;

  assign less   = flags_i.overflow ^ flags_i.sign;
  assign cond_a = (flags_i.over32 | flags_i.top2) & ~flags_i.zero;

  always_comb begin
    unique case (item_i.condition)
      dsfc_pkg::CC_GE:     met = ~less;
      dsfc_pkg::CC_L:      met = less;
      dsfc_pkg::CC_G:      met = ~less & ~flags_i.zero;
      dsfc_pkg::CC_LE:     met = less | flags_i.zero;
      dsfc_pkg::CC_NZ:     met = ~flags_i.zero;
      dsfc_pkg::CC_Z:      met = flags_i.zero;
      dsfc_pkg::CC_NC:     met = ~flags_i.carry;
      dsfc_pkg::CC_C:      met = flags_i.carry;
      dsfc_pkg::CC_NO32:   met = ~flags_i.over32;
      dsfc_pkg::CC_O32:    met = flags_i.over32;
      dsfc_pkg::CC_A:      met = cond_a;
      dsfc_pkg::CC_NA:     met = ~cond_a;
      dsfc_pkg::CC_LNZ:    met = ~flags_i.logic_zero;
      dsfc_pkg::CC_LZ:     met = flags_i.logic_zero;
      dsfc_pkg::CC_O:      met = flags_i.overflow;
      default:             met = 1'b1;
    endcase
  end

  always_comb begin
    flags_o = flags_i;
    met_o   = 1'b0;
    unique case (item_i.operation)
      dsfc_pkg::OP_WIDE_UPDATE: begin
        flags_o.carry    = item_i.carry_in;
        flags_o.overflow = item_i.overflow_in;
        flags_o.sticky   = flags_i.sticky | item_i.overflow_in;
        flags_o.zero     = (item_i.wide_value == 64'sd0);
        flags_o.sign     = item_i.wide_value[63];
        // value is not the sign extension of its low word
        flags_o.over32   = (item_i.wide_value[63:32] != {32{item_i.wide_value[31]}});
        flags_o.top2     = ~(item_i.wide_value[31] ^ item_i.wide_value[30]);
      end
      dsfc_pkg::OP_SHORT_UPDATE: begin
        flags_o.carry    = item_i.carry_in;
        flags_o.overflow = item_i.overflow_in;
        flags_o.sticky   = flags_i.sticky | item_i.overflow_in;
        flags_o.zero     = (item_i.short_value == 16'sd0);
        flags_o.sign     = item_i.short_value[15];
        flags_o.over32   = item_i.over32_in;
        flags_o.top2     = ~(item_i.short_value[15] ^ item_i.short_value[14]);
      end
      dsfc_pkg::OP_SET_LZ: begin
        flags_o.logic_zero = item_i.logic_zero_in;
      end
      dsfc_pkg::OP_CHECK: begin
        met_o = met;
      end
      default: begin
        flags_o = flags_i;
      end
    endcase
  end

endmodule

/* rtl/dsp_status_flags_and_condition_check.sv */
// Top level of the DSP status-flag unit: input register, flag logic, result register.
// An input transfer is registered in stage one, then its result in the output register behind valid_o.
// Throughput: one item per cycle while stall_i is low; the flag register feeds back
// through one level of update logic.
// Reset (rst_ni low, asynchronous): all flags clear, both stages empty.
// Stage one may take a new transfer while a result waits on a stalled output.
module dsp_status_flags_and_condition_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [63:0] wide_value_i,
  input  logic signed [15:0] short_value_i,
  input  logic               carry_in_i,
  input  logic               overflow_in_i,
  input  logic               over32_in_i,
  input  logic               logic_zero_in_i,
  input  logic [3:0]         condition_i,
  // result channel
  output logic               valid_o,
  input  logic               stall_i,
  output logic               condition_met_o,
  output logic [7:0]         flags_out_o
);

  // Stage one: registered input item.
  logic             s1_valid_q, s1_valid_d;
  dsfc_pkg::item_t  s1_item_q;
  // Stage two: registered result, the output register.
  logic             s2_valid_q, s2_valid_d;
  logic             s2_met_q;
  dsfc_pkg::flags_t s2_flags_q;
  // Architectural flag state.
  dsfc_pkg::flags_t flags_q;

  dsfc_pkg::flags_t flags_d;
  logic             met_d;
  logic             s2_free;
  logic             s1_move;
  logic             s1_load;

  // Output register can take a new result when empty or being drained.
  assign s2_free = ~s2_valid_q | ~stall_i;
  assign s1_move = s1_valid_q & s2_free;
  // Stage one holds only while its item is blocked from moving.
  assign stall_o = s1_valid_q & ~s2_free;
  assign s1_load = valid_i & ~stall_o;

  assign s1_valid_d = s1_load | (s1_valid_q & ~s2_free);
  assign s2_valid_d = s1_move | (s2_valid_q & stall_i);

  // The flags only advance when an item leaves stage one, so items see
  // the state left by the one before them in transfer order.
  dsfc_flag_logic u_flag_logic (
    .item_i  (s1_item_q),
    .flags_i (flags_q),
    .flags_o (flags_d),
    .met_o   (met_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      flags_q    <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      if (s1_move) begin
        flags_q <= flags_d;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_item_q.operation     <= dsfc_pkg::op_e'(operation_i);
      s1_item_q.wide_value    <= wide_value_i;
      s1_item_q.short_value   <= short_value_i;
      s1_item_q.carry_in      <= carry_in_i;
      s1_item_q.overflow_in   <= overflow_in_i;
      s1_item_q.over32_in     <= over32_in_i;
      s1_item_q.logic_zero_in <= logic_zero_in_i;
      s1_item_q.condition     <= dsfc_pkg::cond_e'(condition_i);
    end
    if (s1_move) begin
      s2_met_q   <= met_d;
      s2_flags_q <= flags_d;
    end
  end

  assign valid_o         = s2_valid_q;
  assign condition_met_o = s2_met_q;
  assign flags_out_o     = s2_flags_q;

endmodule
